>>> hw/rtl/c3br_pkg.sv
package c3br_pkg;

	// store sizes
	localparam int unsigned MAX_CHANNELS = 32;
	localparam int unsigned MAX_HEIGHT = 64;
	localparam int unsigned MAX_WIDTH = 64;
	localparam int unsigned KSIZE = 3;

	localparam int unsigned SRC_DEPTH = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
	localparam int unsigned WGT_DEPTH = MAX_CHANNELS * MAX_CHANNELS * KSIZE * KSIZE;
	localparam int unsigned SRC_AW = $clog2(SRC_DEPTH);
	localparam int unsigned WGT_AW = $clog2(WGT_DEPTH);
	localparam int unsigned CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	// clamped size widths
	localparam int unsigned CHC_W = $clog2(MAX_CHANNELS + 1);
	localparam int unsigned HC_W = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned WC_W = $clog2(MAX_WIDTH + 1);

	// request field widths
	localparam int unsigned MODE_W = 2;
	localparam int unsigned CH_FW = 5;
	localparam int unsigned ROW_FW = 6;
	localparam int unsigned COL_FW = 6;
	localparam int unsigned K_FW = 2;
	localparam int unsigned VAL_W = 16;
	localparam int unsigned OUT_W = 15;

	// register file
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DW = 7;
	localparam int unsigned IN_CH_RW = 6;
	localparam int unsigned OUT_CH_RW = 6;
	localparam int unsigned HEIGHT_RW = 7;
	localparam int unsigned WIDTH_RW = 7;
	localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd3;

	// request modes
	localparam logic [MODE_W-1:0] MODE_SRC = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WGT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BIAS = 2'd2;
	localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd3;

	// arithmetic
	localparam int unsigned FRAC_BITS = 12;
	localparam int unsigned PROD_W = 2 * VAL_W;
	localparam int unsigned ACC_W = PROD_W - 1 + $clog2(MAX_CHANNELS * KSIZE * KSIZE + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} c3br_state_t;

	typedef struct packed {
		logic load_bias;
		logic prod_v;
	} c3br_mac_ctl_t;

endpackage

>>> hw/rtl/c3br_mac.sv
module c3br_mac (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  c3br_pkg::c3br_mac_ctl_t                    ctl,
	input  logic signed [c3br_pkg::VAL_W-1:0]          bias,
	input  logic signed [c3br_pkg::VAL_W-1:0]          src_s1,
	input  logic signed [c3br_pkg::VAL_W-1:0]          wgt_s1,
	output logic                                       busy,
	output logic [c3br_pkg::OUT_W-1:0]                 result
);
	import c3br_pkg::*;

	logic                      v_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W:0]     rnd;

	// product valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= ctl.prod_v;
		end
	end

	// multiply, then accumulate
	always_ff @(posedge clk) begin
		prod_s2 <= src_s1 * wgt_s1;
		if (ctl.load_bias) begin
			acc_q <= ACC_W'(bias) <<< FRAC_BITS;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	assign busy = v_s2;

	// round half up, clamp at zero, saturate
	always_comb begin
		rnd = (ACC_W + 1)'(acc_q) + (ACC_W + 1)'(1 << (FRAC_BITS - 1));
		if (rnd[ACC_W]) begin
			result = '0;
		end else if (rnd[ACC_W-1:FRAC_BITS+OUT_W] != '0) begin
			result = '1;
		end else begin
			result = rnd[FRAC_BITS+OUT_W-1:FRAC_BITS];
		end
	end

endmodule

>>> hw/rtl/conv3x3_bias_relu_unit.sv
// channel  | dir | handshake              | payload
// cfg      | in  | cfg_we                 | cfg_index, cfg_data
// request  | in  | in_valid / in_stall    | mode, out_channel, in_channel, row, col,
//          |     |                        | kernel_row, kernel_col, value
// result   | out | out_valid / out_stall  | output_value, coord_error
//
// write requests leave the request side open; a compute request steps through the
// clamped in_channels * 9 taps (none when in_channels is 0) up to the result register,
// one tap at a time, through the single shared multiply-accumulate unit and the one
// read port of each store; a compute request with bad coordinates skips the taps
// in_stall is high while a compute request is in work; a stalled result holds the
// unit in its drain step until taken
// reset initialises control and config only; the stores hold garbage until written
module conv3x3_bias_relu_unit (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [c3br_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [c3br_pkg::CFG_DW-1:0]              cfg_data,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic [c3br_pkg::MODE_W-1:0]              mode,
	input  logic [c3br_pkg::CH_FW-1:0]               out_channel,
	input  logic [c3br_pkg::CH_FW-1:0]               in_channel,
	input  logic [c3br_pkg::ROW_FW-1:0]              row,
	input  logic [c3br_pkg::COL_FW-1:0]              col,
	input  logic [c3br_pkg::K_FW-1:0]                kernel_row,
	input  logic [c3br_pkg::K_FW-1:0]                kernel_col,
	input  logic signed [c3br_pkg::VAL_W-1:0]        value,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic [c3br_pkg::OUT_W-1:0]               output_value,
	output logic                                     coord_error
);
	import c3br_pkg::*;

	function automatic logic [SRC_AW-1:0] src_index(input logic [31:0] ch,
		input logic [31:0] r, input logic [31:0] c);
		logic [31:0] t;
		t = (ch * MAX_HEIGHT + r) * MAX_WIDTH + c;
		return t[SRC_AW-1:0];
	endfunction

	function automatic logic [WGT_AW-1:0] wgt_index(input logic [31:0] oc,
		input logic [31:0] ic, input logic [31:0] kr, input logic [31:0] kc);
		logic [31:0] t;
		t = ((oc * MAX_CHANNELS + ic) * KSIZE + kr) * KSIZE + kc;
		return t[WGT_AW-1:0];
	endfunction

	c3br_state_t state_q, state_d;

	logic [IN_CH_RW-1:0]  in_channels_q;
	logic [OUT_CH_RW-1:0] out_channels_q;
	logic [HEIGHT_RW-1:0] height_q;
	logic [WIDTH_RW-1:0]  width_q;

	logic [CHC_W-1:0] nic, noc;
	logic [HC_W-1:0]  h;
	logic [WC_W-1:0]  w;

	logic in_acc, compute_acc, coord_err;
	logic src_we, wgt_we, bias_we;
	logic issue, last, load_out, tap_in;

	logic [CH_FW-1:0]  oc_q;
	logic [ROW_FW-1:0] r_q;
	logic [COL_FW-1:0] c_q;
	logic [CH_W-1:0]   ch_q;
	logic [K_FW-1:0]   kr_q, kc_q;
	logic              first_q, err_q, v_s1_q;
	logic [ROW_FW:0]   rs;
	logic [COL_FW:0]   cs;

	logic [SRC_AW-1:0] src_waddr, src_raddr;
	logic [WGT_AW-1:0] wgt_waddr, wgt_raddr;

	logic signed [VAL_W-1:0] src_mem [SRC_DEPTH];
	logic signed [VAL_W-1:0] wgt_mem [WGT_DEPTH];
	logic signed [VAL_W-1:0] bias_mem [MAX_CHANNELS];
	logic signed [VAL_W-1:0] src_rd_s1, wgt_rd_s1, bias_rd_q;

	c3br_mac_ctl_t     mac_ctl;
	logic              mac_busy;
	logic [OUT_W-1:0]  mac_result;

	logic              out_valid_q;
	logic [OUT_W-1:0]  output_value_q;
	logic              coord_error_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_channels_q  <= IN_CH_RW'(16);
			out_channels_q <= OUT_CH_RW'(16);
			height_q       <= HEIGHT_RW'(64);
			width_q        <= WIDTH_RW'(64);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IN_CHANNELS:  in_channels_q  <= cfg_data[IN_CH_RW-1:0];
				REG_OUT_CHANNELS: out_channels_q <= cfg_data[OUT_CH_RW-1:0];
				REG_HEIGHT:       height_q       <= cfg_data[HEIGHT_RW-1:0];
				REG_WIDTH:        width_q        <= cfg_data[WIDTH_RW-1:0];
				default: ;
			endcase
		end
	end

	// sizes clamped to the store limits
	assign nic = (32'(in_channels_q) > MAX_CHANNELS) ? CHC_W'(MAX_CHANNELS)
		: CHC_W'(in_channels_q);
	assign noc = (32'(out_channels_q) > MAX_CHANNELS) ? CHC_W'(MAX_CHANNELS)
		: CHC_W'(out_channels_q);
	assign h = (32'(height_q) > MAX_HEIGHT) ? HC_W'(MAX_HEIGHT) : HC_W'(height_q);
	assign w = (32'(width_q) > MAX_WIDTH) ? WC_W'(MAX_WIDTH) : WC_W'(width_q);

	// request decode
	assign in_acc = in_valid && !in_stall;
	assign compute_acc = in_acc && (mode == MODE_COMPUTE);
	assign coord_err = (32'(out_channel) >= 32'(noc)) || (32'(row) >= 32'(h))
		|| (32'(col) >= 32'(w));

	assign src_we = in_acc && (mode == MODE_SRC) && (32'(in_channel) < MAX_CHANNELS)
		&& (32'(row) < MAX_HEIGHT) && (32'(col) < MAX_WIDTH);
	assign wgt_we = in_acc && (mode == MODE_WGT) && (32'(out_channel) < MAX_CHANNELS)
		&& (32'(in_channel) < MAX_CHANNELS) && (32'(kernel_row) < KSIZE)
		&& (32'(kernel_col) < KSIZE);
	assign bias_we = in_acc && (mode == MODE_BIAS) && (32'(out_channel) < MAX_CHANNELS);

	assign src_waddr = src_index(32'(in_channel), 32'(row), 32'(col));
	assign wgt_waddr = wgt_index(32'(out_channel), 32'(in_channel), 32'(kernel_row),
		32'(kernel_col));

	// tap position, one above the real row and column
	assign rs = (ROW_FW + 1)'(r_q) + (ROW_FW + 1)'(kr_q);
	assign cs = (COL_FW + 1)'(c_q) + (COL_FW + 1)'(kc_q);
	assign tap_in = (rs != '0) && (32'(rs) <= 32'(h)) && (cs != '0)
		&& (32'(cs) <= 32'(w));
	assign src_raddr = tap_in ? src_index(32'(ch_q), 32'(rs) - 32'd1, 32'(cs) - 32'd1)
		: '0;
	assign wgt_raddr = wgt_index(32'(oc_q), 32'(ch_q), 32'(kr_q), 32'(kc_q));

	assign last = (nic == '0) || ((32'(ch_q) + 32'd1 == 32'(nic))
		&& (32'(kr_q) == KSIZE - 1) && (32'(kc_q) == KSIZE - 1));

	// stores
	always_ff @(posedge clk) begin
		if (src_we) begin
			src_mem[src_waddr] <= value;
		end
		src_rd_s1 <= src_mem[src_raddr];
	end

	always_ff @(posedge clk) begin
		if (wgt_we) begin
			wgt_mem[wgt_waddr] <= value;
		end
		wgt_rd_s1 <= wgt_mem[wgt_raddr];
	end

	always_ff @(posedge clk) begin
		if (bias_we) begin
			bias_mem[CH_W'(out_channel)] <= value;
		end
		if (compute_acc) begin
			bias_rd_q <= bias_mem[CH_W'(out_channel)];
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and step controls
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		issue    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && (mode == MODE_COMPUTE)) begin
					state_d = coord_err ? ST_DRAIN : ST_RUN;
				end
			end
			ST_RUN: begin
				issue = (nic != '0);
				if (last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1_q && !mac_busy && (!out_valid_q || !out_stall)) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// tap counters and pipeline flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q    <= '0;
			kr_q    <= '0;
			kc_q    <= '0;
			first_q <= 1'b0;
			err_q   <= 1'b0;
			v_s1_q  <= 1'b0;
		end else begin
			v_s1_q <= issue && tap_in;
			if (compute_acc) begin
				ch_q    <= '0;
				kr_q    <= '0;
				kc_q    <= '0;
				first_q <= 1'b1;
				err_q   <= coord_err;
			end else if (state_q == ST_RUN) begin
				first_q <= 1'b0;
				if (issue && !last) begin
					if (32'(kc_q) == KSIZE - 1) begin
						kc_q <= '0;
						if (32'(kr_q) == KSIZE - 1) begin
							kr_q <= '0;
							ch_q <= ch_q + CH_W'(1);
						end else begin
							kr_q <= kr_q + K_FW'(1);
						end
					end else begin
						kc_q <= kc_q + K_FW'(1);
					end
				end
			end
		end
	end

	// request coordinates
	always_ff @(posedge clk) begin
		if (compute_acc) begin
			oc_q <= out_channel;
			r_q  <= row;
			c_q  <= col;
		end
	end

	assign mac_ctl.load_bias = first_q && (state_q == ST_RUN);
	assign mac_ctl.prod_v    = v_s1_q;

	c3br_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.bias   (bias_rd_q),
		.src_s1 (src_rd_s1),
		.wgt_s1 (wgt_rd_s1),
		.busy   (mac_busy),
		.result (mac_result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			output_value_q <= err_q ? '0 : mac_result;
			coord_error_q  <= err_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign output_value = output_value_q;
	assign coord_error  = coord_error_q;

endmodule

>>> hw/rtl/c3br_check.sv
module c3br_check (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic [c3br_pkg::MODE_W-1:0]       mode,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [c3br_pkg::OUT_W-1:0]        output_value,
	input logic                              coord_error
);
	import c3br_pkg::*;

	// a compute request blocks the next request
	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (mode == MODE_COMPUTE) |=> in_stall)
		else $error("compute request did not raise in_stall");

	// write requests keep the request side open
	a_write_open: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (mode != MODE_COMPUTE) |=> !in_stall)
		else $error("write request stalled the next request");

	// coordinate error gives a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && coord_error |-> (output_value == '0))
		else $error("coordinate error with nonzero value");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(output_value)
		&& $stable(coord_error))
		else $error("stalled result changed");

endmodule

bind conv3x3_bias_relu_unit c3br_check u_c3br_check (.*);

>>> bench/tb_conv3x3_bias_relu_unit.sv
`timescale 1ns / 100ps

module tb_conv3x3_bias_relu_unit;
	import c3br_pkg::*;

	localparam int QUIET_LIMIT = 5000;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [CH_FW-1:0]  oc;
		logic [CH_FW-1:0]  ic;
		logic [ROW_FW-1:0] row;
		logic [COL_FW-1:0] col;
		logic [K_FW-1:0]   kr;
		logic [K_FW-1:0]   kc;
		logic [VAL_W-1:0]  val;
	} conv_req_t;

	typedef struct packed {
		logic [OUT_W-1:0] pix;
		logic             err;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [MODE_W-1:0] mode = '0;
	logic [CH_FW-1:0] out_channel = '0;
	logic [CH_FW-1:0] in_channel = '0;
	logic [ROW_FW-1:0] row = '0;
	logic [COL_FW-1:0] col = '0;
	logic [K_FW-1:0] kernel_row = '0;
	logic [K_FW-1:0] kernel_col = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [OUT_W-1:0] output_value;
	logic coord_error;

	// predictor state: register copies and store contents
	logic [5:0] in_ch_reg = 6'd16;
	logic [5:0] out_ch_reg = 6'd16;
	logic [6:0] height_reg = 7'd64;
	logic [6:0] width_reg = 7'd64;
	logic [VAL_W-1:0] src_mem [SRC_DEPTH];
	logic [VAL_W-1:0] wgt_mem [WGT_DEPTH];
	logic [VAL_W-1:0] bias_mem [MAX_CHANNELS];

	// entries already written by queued requests
	bit src_set [SRC_DEPTH];
	bit wgt_set [WGT_DEPTH];
	bit bias_set [MAX_CHANNELS];

	conv_req_t req_q [$];
	pixel_t pixel_q [$];
	conv_req_t cur_req;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int queued_count = 0;
	int sent_count = 0;
	int pixel_count = 0;
	int coord_err_count = 0;
	int fail_count = 0;
	int quiet_cycles = 0;

	conv3x3_bias_relu_unit uut (.*);

	// clock
	always #6 clk = ~clk;

	function automatic int src_addr(int ch, int r, int c);
		return (ch * MAX_HEIGHT + r) * MAX_WIDTH + c;
	endfunction

	function automatic int wgt_addr(int oc, int ic, int kr, int kc);
		return ((oc * MAX_CHANNELS + ic) * KSIZE + kr) * KSIZE + kc;
	endfunction

	function automatic int clamp_size(int v, int m);
		return (v > m) ? m : v;
	endfunction

	// convolution at one pixel from the current stores and sizes
	function automatic pixel_t predict_pixel(conv_req_t rq);
		pixel_t px;
		longint acc;
		int nic, noc, hh, ww, oc, r, c, ir, icl;
		nic = clamp_size(int'(in_ch_reg), MAX_CHANNELS);
		noc = clamp_size(int'(out_ch_reg), MAX_CHANNELS);
		hh = clamp_size(int'(height_reg), MAX_HEIGHT);
		ww = clamp_size(int'(width_reg), MAX_WIDTH);
		oc = int'(rq.oc);
		r = int'(rq.row);
		c = int'(rq.col);
		px = '0;
		if (oc >= noc || r >= hh || c >= ww) begin
			px.err = 1'b1;
			return px;
		end
		acc = longint'($signed(bias_mem[oc])) * 4096;
		for (int ch = 0; ch < nic; ch++) begin
			for (int a = 0; a < KSIZE; a++) begin
				ir = r + a - 1;
				if (ir < 0 || ir >= hh) continue;
				for (int b = 0; b < KSIZE; b++) begin
					icl = c + b - 1;
					if (icl < 0 || icl >= ww) continue;
					acc += longint'($signed(src_mem[src_addr(ch, ir, icl)]))
						* longint'($signed(wgt_mem[wgt_addr(oc, ch, a, b)]));
				end
			end
		end
		acc += 2048;
		// relu, then saturate to 15 bits
		if (acc >= 0)
			px.pix = ((acc >>> 12) > 32767) ? 15'h7fff : 15'(acc >>> 12);
		return px;
	endfunction

	// update stores or queue the expected pixel for an accepted request
	function automatic void apply_request(conv_req_t rq);
		case (rq.mode)
			MODE_SRC: src_mem[src_addr(int'(rq.ic), int'(rq.row), int'(rq.col))] = rq.val;
			MODE_WGT: begin
				if (rq.kr < KSIZE && rq.kc < KSIZE)
					wgt_mem[wgt_addr(int'(rq.oc), int'(rq.ic), int'(rq.kr),
						int'(rq.kc))] = rq.val;
			end
			MODE_BIAS: bias_mem[rq.oc] = rq.val;
			MODE_COMPUTE: pixel_q.push_back(predict_pixel(rq));
			default: ;
		endcase
	endfunction

	// data word: mostly small magnitudes so sums stay in range
	function automatic logic [VAL_W-1:0] rand_word();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5)
			return 16'($signed($urandom_range(0, 4095)) - 2048);
		else if (sel < 8)
			return 16'($signed($urandom_range(0, 16383)) - 8192);
		return 16'($urandom());
	endfunction

	// index below lim most of the time, anywhere in the field otherwise
	function automatic int pick(int lim, int full);
		if (lim > 0 && $urandom_range(0, 9) != 0)
			return $urandom_range(0, lim - 1);
		return $urandom_range(0, full - 1);
	endfunction

	// queue a request; fields the mode does not use get random values
	function automatic void push_req(logic [MODE_W-1:0] md, int oc, int ic, int r, int c,
			int kr, int kc, logic [VAL_W-1:0] v);
		conv_req_t rq;
		rq = conv_req_t'({$urandom(), $urandom()});
		rq.mode = md;
		case (md)
			MODE_SRC: begin
				rq.ic = CH_FW'(ic);
				rq.row = ROW_FW'(r);
				rq.col = COL_FW'(c);
				rq.val = v;
				src_set[src_addr(ic, r, c)] = 1'b1;
			end
			MODE_WGT: begin
				rq.oc = CH_FW'(oc);
				rq.ic = CH_FW'(ic);
				rq.kr = K_FW'(kr);
				rq.kc = K_FW'(kc);
				rq.val = v;
				if (kr < KSIZE && kc < KSIZE)
					wgt_set[wgt_addr(oc, ic, kr, kc)] = 1'b1;
			end
			MODE_BIAS: begin
				rq.oc = CH_FW'(oc);
				rq.val = v;
				bias_set[oc] = 1'b1;
			end
			MODE_COMPUTE: begin
				rq.oc = CH_FW'(oc);
				rq.row = ROW_FW'(r);
				rq.col = COL_FW'(c);
			end
			default: ;
		endcase
		// ignored tap writes do not count
		if (!(md == MODE_WGT && (kr >= KSIZE || kc >= KSIZE)))
			queued_count++;
		req_q.push_back(rq);
	endfunction

	// compute request, preceded by writes of any unwritten entry it may read
	function automatic void queue_pixel(int oc, int r, int c);
		int nic, noc, hh, ww, rr, cc;
		nic = clamp_size(int'(in_ch_reg), MAX_CHANNELS);
		noc = clamp_size(int'(out_ch_reg), MAX_CHANNELS);
		hh = clamp_size(int'(height_reg), MAX_HEIGHT);
		ww = clamp_size(int'(width_reg), MAX_WIDTH);
		if (oc < noc && r < hh && c < ww) begin
			if (!bias_set[oc])
				push_req(MODE_BIAS, oc, 0, 0, 0, 0, 0, rand_word());
			for (int ch = 0; ch < nic; ch++) begin
				for (int a = 0; a < KSIZE; a++) begin
					for (int b = 0; b < KSIZE; b++) begin
						if (!wgt_set[wgt_addr(oc, ch, a, b)])
							push_req(MODE_WGT, oc, ch, 0, 0, a, b, rand_word());
						rr = r + a - 1;
						cc = c + b - 1;
						if (rr >= 0 && rr < MAX_HEIGHT && cc >= 0 && cc < MAX_WIDTH
								&& !src_set[src_addr(ch, rr, cc)])
							push_req(MODE_SRC, 0, ch, rr, cc, 0, 0, rand_word());
					end
				end
			end
		end
		push_req(MODE_COMPUTE, oc, 0, r, c, 0, 0, '0);
	endfunction

	function automatic void gen_random_item();
		int nic, noc, hh, ww, sel, kr, kc;
		nic = clamp_size(int'(in_ch_reg), MAX_CHANNELS);
		noc = clamp_size(int'(out_ch_reg), MAX_CHANNELS);
		hh = clamp_size(int'(height_reg), MAX_HEIGHT);
		ww = clamp_size(int'(width_reg), MAX_WIDTH);
		sel = $urandom_range(0, 99);
		if (sel < 25) begin
			push_req(MODE_SRC, 0, pick(nic, 32), pick(hh, 64), pick(ww, 64), 0, 0, rand_word());
		end else if (sel < 45) begin
			kr = ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2);
			kc = ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2);
			push_req(MODE_WGT, pick(noc, 32), pick(nic, 32), 0, 0, kr, kc, rand_word());
		end else if (sel < 52) begin
			push_req(MODE_BIAS, pick(noc, 32), 0, 0, 0, 0, 0, rand_word());
		end else if ($urandom_range(0, 9) == 0) begin
			queue_pixel($urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
		end else begin
			queue_pixel(pick(noc, 32), pick(hh, 64), pick(ww, 64));
		end
	endfunction

	// register write, model copy follows
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] d);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		case (idx)
			REG_IN_CHANNELS: in_ch_reg = d[5:0];
			REG_OUT_CHANNELS: out_ch_reg = d[5:0];
			REG_HEIGHT: height_reg = d;
			REG_WIDTH: width_reg = d;
			default: ;
		endcase
	endtask

	task automatic set_sizes(input int ic, input int oc, input int h, input int w);
		write_reg(REG_IN_CHANNELS, 7'(ic));
		write_reg(REG_OUT_CHANNELS, 7'(oc));
		write_reg(REG_HEIGHT, 7'(h));
		write_reg(REG_WIDTH, 7'(w));
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// wait until every request is taken and every pixel has come back
	task automatic drain();
		do @(negedge clk);
		while (req_q.size() != 0 || in_valid || pixel_q.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				apply_request(cur_req);
				sent_count++;
			end
			if (!in_valid || !in_stall) begin
				if (req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					cur_req = req_q.pop_front();
					mode <= cur_req.mode;
					out_channel <= cur_req.oc;
					in_channel <= cur_req.ic;
					row <= cur_req.row;
					col <= cur_req.col;
					kernel_row <= cur_req.kr;
					kernel_col <= cur_req.kc;
					value <= cur_req.val;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and checker
	always @(posedge clk or negedge arst_n) begin
		pixel_t exp_px;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pixel_q.size() == 0) begin
					$display("%0t: unexpected result, value %0d coord_error %0b",
						$time, output_value, coord_error);
					fail_count++;
				end else begin
					exp_px = pixel_q.pop_front();
					pixel_count++;
					if (exp_px.err)
						coord_err_count++;
					if (output_value !== exp_px.pix) begin
						$display("%0t: output_value mismatch, expected %0d actual %0d",
							$time, exp_px.pix, output_value);
						fail_count++;
					end
					if (coord_error !== exp_px.err) begin
						$display("%0t: coord_error mismatch, expected %0b actual %0b",
							$time, exp_px.err, coord_error);
						fail_count++;
					end
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// watchdog on cycles with no transfer at all
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// stimulus
	initial begin
		int budget;
		int start;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < 14; p++) begin
			// idling regime
			if (p <= 4) begin
				send_idle_pct = 13;
				recv_idle_pct = 56;
			end else if (p <= 9) begin
				send_idle_pct = 56;
				recv_idle_pct = 13;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			budget = 0;
			case (p)
				0: set_sizes(1, 2, 64, 64);
				1: begin set_sizes(2, 3, 5, 7); budget = 40; end
				// no input channels: bias only
				2: begin set_sizes(0, 2, 3, 3); budget = 25; end
				// bit 6 of the channel count is dropped
				3: begin set_sizes(7'h43, 4, 8, 6); budget = 30; end
				// zero sizes: every pixel is a coordinate error
				4: begin set_sizes(1, 0, 4, 4); budget = 10; end
				5: begin set_sizes(1, 2, 0, 4); budget = 10; end
				6: begin set_sizes(1, 2, 4, 0); budget = 10; end
				// sizes above the store limits
				7: set_sizes(63, 63, 127, 127);
				8: begin set_sizes(1, 1, 1, 1); budget = 20; end
				9: begin set_sizes(1, 2, 64, 64); budget = 30; end
				default: begin
					set_sizes($urandom_range(0, 4), $urandom_range(1, 4),
						$urandom_range(1, 10), $urandom_range(1, 10));
					budget = 25;
				end
			endcase
			if (p == 0) begin
				// field extremes and ignored tap indexes
				push_req(MODE_BIAS, 31, 0, 0, 0, 0, 0, 16'h1234);
				push_req(MODE_SRC, 0, 31, 63, 63, 0, 0, 16'h7fff);
				push_req(MODE_WGT, 31, 31, 0, 0, 2, 2, 16'h8000);
				push_req(MODE_WGT, 0, 0, 0, 0, 3, 1, 16'h7fff);
				push_req(MODE_WGT, 0, 0, 0, 0, 1, 3, 16'h7fff);
				for (int a = 0; a < KSIZE; a++)
					for (int b = 0; b < KSIZE; b++)
						push_req(MODE_WGT, 0, 0, 0, 0, a, b, 16'h7fff);
				// large negative sum clamps to zero
				push_req(MODE_BIAS, 0, 0, 0, 0, 0, 0, 16'h8000);
				for (int a = 62; a < 64; a++)
					for (int b = 62; b < 64; b++)
						push_req(MODE_SRC, 0, 0, a, b, 0, 0, 16'h8000);
				queue_pixel(0, 63, 63);
				// large positive sum saturates
				push_req(MODE_BIAS, 0, 0, 0, 0, 0, 0, 16'h7fff);
				for (int a = 0; a < 2; a++)
					for (int b = 0; b < 2; b++)
						push_req(MODE_SRC, 0, 0, a, b, 0, 0, 16'h7fff);
				queue_pixel(0, 0, 0);
				queue_pixel(31, 0, 0);
			end else if (p == 7) begin
				queue_pixel(31, 63, 63);
			end else begin
				start = queued_count;
				while (queued_count - start < budget)
					gen_random_item();
			end
			drain();
		end
		repeat (20) @(posedge clk);
		$display("%0d requests over 14 size settings, %0d pixels checked", sent_count, pixel_count);
		$display("%0d of those pixels were coordinate errors", coord_err_count);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
